@@ rtl/sfc_pkg.sv @@
`default_nettype none

package sfc_pkg;

    localparam int NUM_PLANES       = 6;
    localparam int NORMAL_FRAC_BITS = 14;
    // s^2 carries 2*14 more fraction bits than size^2; the quarter removes two
    localparam int SQ_SHIFT         = 2 * NORMAL_FRAC_BITS - 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CAM_W      = 48;

    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA = CFG_ADDR_W'(NUM_PLANES);

    localparam logic [7:0] ALPHA_MIN = 8'd3;

    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_CUTOUT = 2'd1;
    localparam logic [1:0] MODE_TRANSP = 2'd2;
    localparam logic [1:0] MODE_OTHER  = 2'd3;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] size_x;
        logic signed [15:0] size_y;
        logic [7:0]         alpha;
        logic [1:0]         blend_mode;
        logic [7:0]         layer;
        logic [31:0]        entity_handle;
    } t_in_req;

    typedef struct packed {
        logic        keep;
        logic [1:0]  queue_select;
        logic [7:0]  layer_out;
        logic [31:0] handle_out;
        logic [33:0] sort_distance;
    } t_out_req;

    // load enables of stages one to four
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctl;

    typedef struct packed {
        logic        alpha_ok;
        logic [1:0]  blend_mode;
        logic [7:0]  layer;
        logic [31:0] handle;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/sfc_plane_unit.sv @@
`default_nettype none

module sfc_plane_unit
    import sfc_pkg::*;
(
    input  wire                i_clk,
    input  wire t_pipe_ctl     i_ctl,
    input  wire [63:0]         i_plane,
    input  wire signed [15:0]  i_px,
    input  wire signed [15:0]  i_py,
    input  wire signed [15:0]  i_pz,
    output logic               o_neg,
    output logic [63:0]        o_sq
);

    logic signed [15:0] w_nx, w_ny, w_nz;
    logic signed [31:0] w_p0, w_p1, w_p2;
    logic signed [33:0] w_d_ext;
    logic signed [33:0] n_s;

    logic signed [31:0] r_p0, r_p1, r_p2;
    logic signed [15:0] r_d;
    logic signed [33:0] r_s;
    logic               r_neg3, r_neg4;
    logic [31:0]        r_mag;
    logic [63:0]        r_sq;

    assign w_nx = $signed(i_plane[15:0]);
    assign w_ny = $signed(i_plane[31:16]);
    assign w_nz = $signed(i_plane[47:32]);

    assign w_p0 = 32'(w_nx) * 32'(i_px);
    assign w_p1 = 32'(w_ny) * 32'(i_py);
    assign w_p2 = 32'(w_nz) * 32'(i_pz);

    assign w_d_ext = $signed({{4{r_d[15]}}, r_d, {NORMAL_FRAC_BITS{1'b0}}});
    assign n_s     = $signed({{2{r_p0[31]}}, r_p0}) + $signed({{2{r_p1[31]}}, r_p1})
                   + $signed({{2{r_p2[31]}}, r_p2}) + w_d_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_p0 <= w_p0;
            r_p1 <= w_p1;
            r_p2 <= w_p2;
            r_d  <= $signed(i_plane[63:48]);
        end
        if (i_ctl.en2) begin
            r_s <= n_s;
        end
        // |s| stays below 2^32 when s is negative
        if (i_ctl.en3) begin
            r_neg3 <= r_s[33];
            r_mag  <= r_s[33] ? 32'(-r_s) : 32'(r_s);
        end
        if (i_ctl.en4) begin
            r_neg4 <= r_neg3;
            r_sq   <= 64'(r_mag) * 64'(r_mag);
        end
    end

    assign o_neg = r_neg4;
    assign o_sq  = r_sq;

endmodule

`default_nettype wire

@@ rtl/sfc_size_dist.sv @@
`default_nettype none

module sfc_size_dist
    import sfc_pkg::*;
(
    input  wire                i_clk,
    input  wire t_pipe_ctl     i_ctl,
    input  wire [CAM_W-1:0]    i_camera,
    input  wire signed [15:0]  i_px,
    input  wire signed [15:0]  i_py,
    input  wire signed [15:0]  i_pz,
    input  wire signed [15:0]  i_sx,
    input  wire signed [15:0]  i_sy,
    output logic [31:0]        o_r2x4,
    output logic [33:0]        o_dist
);

    logic signed [31:0] w_sx2, w_sy2;
    logic signed [16:0] w_dx, w_dy, w_dz;
    logic signed [33:0] w_dx2, w_dy2, w_dz2;

    logic [30:0]        r_sx2, r_sy2;
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [31:0]        r_r2x4_2, r_r2x4_3, r_r2x4_4;
    logic [31:0]        r_dx2, r_dy2, r_dz2;
    logic [33:0]        r_dist_3, r_dist_4;

    assign w_sx2 = 32'(i_sx) * 32'(i_sx);
    assign w_sy2 = 32'(i_sy) * 32'(i_sy);

    assign w_dx = $signed({i_px[15], i_px} - {i_camera[15], i_camera[15:0]});
    assign w_dy = $signed({i_py[15], i_py} - {i_camera[31], i_camera[31:16]});
    assign w_dz = $signed({i_pz[15], i_pz} - {i_camera[47], i_camera[47:32]});

    assign w_dx2 = 34'(r_dx) * 34'(r_dx);
    assign w_dy2 = 34'(r_dy) * 34'(r_dy);
    assign w_dz2 = 34'(r_dz) * 34'(r_dz);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_sx2 <= w_sx2[30:0];
            r_sy2 <= w_sy2[30:0];
            r_dx  <= w_dx;
            r_dy  <= w_dy;
            r_dz  <= w_dz;
        end
        if (i_ctl.en2) begin
            r_r2x4_2 <= 32'(r_sx2) + 32'(r_sy2);
            r_dx2    <= w_dx2[31:0];
            r_dy2    <= w_dy2[31:0];
            r_dz2    <= w_dz2[31:0];
        end
        if (i_ctl.en3) begin
            r_r2x4_3 <= r_r2x4_2;
            r_dist_3 <= 34'(r_dx2) + 34'(r_dy2) + 34'(r_dz2);
        end
        if (i_ctl.en4) begin
            r_r2x4_4 <= r_r2x4_3;
            r_dist_4 <= r_dist_3;
        end
    end

    assign o_r2x4 = r_r2x4_4;
    assign o_dist = r_dist_4;

endmodule

`default_nettype wire

@@ rtl/sprite_frustum_cull_classify.sv @@
`default_nettype none

// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------
// request   | i_valid / o_stall   | i_req (t_in_req)
// result    | o_valid / i_stall   | o_req (t_out_req)
// config    | i_cfg_we            | i_cfg_addr, i_cfg_wdata
//
// One request per cycle while o_stall is low; each result is registered through
// the stages in order (products, plane sums, magnitude, square, compare and route).
// The six 32x32 squaring multipliers set the stage depth.
// Reset clears the plane and camera registers and all valid bits.
// Each stage holds while the next one is full and stalled, so bubbles close
// up; requests stall only once every stage holds a request behind a stalled result.

module sprite_frustum_cull_classify
    import sfc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire t_in_req          i_req,
    output logic                  o_valid,
    input  wire                   i_stall,
    output t_out_req              o_req,
    input  wire                   i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_plane [NUM_PLANES];
    logic [CAM_W-1:0]      r_camera;

    logic [4:1] r_vld;
    logic       r_out_vld;
    t_side      r_side [1:4];
    t_out_req   r_out;

    logic [5:1] w_rdy;
    t_pipe_ctl  w_ctl;
    t_side      w_side0;

    logic        w_neg [NUM_PLANES];
    logic [63:0] w_sq  [NUM_PLANES];
    logic [31:0] w_r2x4;
    logic [33:0] w_dist;
    logic [63:0] w_rhs;
    logic        w_cull;
    logic        w_keep;
    t_out_req    n_out;

    // a stage loads when it is empty or its successor moves on
    assign w_rdy[5] = !r_out_vld || !i_stall;
    assign w_rdy[4] = !r_vld[4] || w_rdy[5];
    assign w_rdy[3] = !r_vld[3] || w_rdy[4];
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];

    assign o_stall   = !w_rdy[1];
    assign w_ctl.en1 = w_rdy[1];
    assign w_ctl.en2 = w_rdy[2];
    assign w_ctl.en3 = w_rdy[3];
    assign w_ctl.en4 = w_rdy[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_plane[i] <= '0;
            end
            r_camera <= '0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                if (i_cfg_addr == CFG_ADDR_W'(i)) begin
                    r_plane[i] <= i_cfg_wdata;
                end
            end
            if (i_cfg_addr == CFG_CAMERA) begin
                r_camera <= i_cfg_wdata[CAM_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        sfc_plane_unit u_plane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_plane (r_plane[g]),
            .i_px    (i_req.pos_x),
            .i_py    (i_req.pos_y),
            .i_pz    (i_req.pos_z),
            .o_neg   (w_neg[g]),
            .o_sq    (w_sq[g])
        );
    end

    sfc_size_dist u_size_dist (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_camera (r_camera),
        .i_px     (i_req.pos_x),
        .i_py     (i_req.pos_y),
        .i_pz     (i_req.pos_z),
        .i_sx     (i_req.size_x),
        .i_sy     (i_req.size_y),
        .o_r2x4   (w_r2x4),
        .o_dist   (w_dist)
    );

    assign w_side0.alpha_ok   = i_req.alpha >= ALPHA_MIN;
    assign w_side0.blend_mode = i_req.blend_mode;
    assign w_side0.layer      = i_req.layer;
    assign w_side0.handle     = i_req.entity_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_rdy[1]) r_vld[1] <= i_valid;
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
            if (w_rdy[4]) r_vld[4] <= r_vld[3];
            if (w_rdy[5]) r_out_vld <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) r_side[1] <= w_side0;
        if (w_rdy[2]) r_side[2] <= r_side[1];
        if (w_rdy[3]) r_side[3] <= r_side[2];
        if (w_rdy[4]) r_side[4] <= r_side[3];
        if (w_rdy[5]) r_out     <= n_out;
    end

    // culled when some plane has s < 0 and s^2 above the quartered size^2
    assign w_rhs = 64'(w_r2x4) << SQ_SHIFT;

    always_comb begin
        w_cull = 1'b0;
        for (int i = 0; i < NUM_PLANES; i++) begin
            if (w_neg[i] && (w_sq[i] > w_rhs)) begin
                w_cull = 1'b1;
            end
        end
    end

    assign w_keep = r_side[4].alpha_ok && !w_cull && (r_side[4].blend_mode != MODE_OTHER);

    always_comb begin
        n_out.keep          = w_keep;
        n_out.queue_select  = MODE_OPAQUE;
        n_out.layer_out     = r_side[4].layer;
        n_out.handle_out    = r_side[4].handle;
        n_out.sort_distance = '0;
        if (w_keep) begin
            case (r_side[4].blend_mode)
                MODE_OPAQUE: n_out.queue_select = MODE_OPAQUE;
                MODE_CUTOUT: n_out.queue_select = MODE_CUTOUT;
                MODE_TRANSP: begin
                    n_out.queue_select  = MODE_TRANSP;
                    n_out.sort_distance = w_dist;
                end
                default:     n_out.queue_select = MODE_OPAQUE;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_req   = r_out;

endmodule

`default_nettype wire
